// File: rtl/ckf_pkg.sv
// ----------------------------------------------------------------------------
// ckf_pkg: shared types, constants and bucket helpers
// Sizes of the bucket store, fingerprint reduction constants, status codes,
// sequencer states and small functions that build the index mask or inspect or update one bucket.
// ----------------------------------------------------------------------------
package ckf_pkg;

  localparam int MAX_BUCKETS      = 1024;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int FINGERPRINT_BITS = 7;
  localparam int MAX_KICKS        = 500;

  localparam int HASH_W    = 64;
  localparam int CFG_W     = 4;
  localparam int IDX_W     = $clog2(MAX_BUCKETS);
  localparam int SLOT_W    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int KICK_W    = $clog2(MAX_KICKS + 1);
  localparam int FP_MOD    = (1 << FINGERPRINT_BITS) - 1;
  localparam int DIGITS    = (HASH_W + FINGERPRINT_BITS - 1) / FINGERPRINT_BITS;
  localparam int DIG_CNT_W = $clog2(DIGITS);
  localparam int CFG_RESET = 10;

  typedef logic [FINGERPRINT_BITS-1:0]                       fp_t;
  typedef logic [IDX_W-1:0]                                  idx_t;
  typedef logic [SLOTS_PER_BUCKET-1:0][FINGERPRINT_BITS-1:0] bucket_t;

  typedef enum logic [1:0] {
    STATUS_LOOKUP   = 2'd0,
    STATUS_INSERTED = 2'd1,
    STATUS_PRESENT  = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_RD1,
    ST_RD2,
    ST_CHECK,
    ST_KREAD,
    ST_KCHECK
  } state_t;

  typedef struct packed {
    logic    we;
    idx_t    addr;
    bucket_t wdata;
  } ram_req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } empty_t;

  function automatic idx_t index_mask(logic [CFG_W-1:0] k);
    logic [CFG_W-1:0] kc;
    kc = k;
    if (kc < CFG_W'(1)) begin
      kc = CFG_W'(1);
    end else if (kc > CFG_W'(IDX_W)) begin
      kc = CFG_W'(IDX_W);
    end
    return ~({IDX_W{1'b1}} << kc);
  endfunction

  function automatic logic bucket_holds(bucket_t b, fp_t fp);
    logic r;
    r = 1'b0;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (b[s] == fp) begin
        r = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic empty_t first_empty(bucket_t b);
    empty_t r;
    r = '{found: 1'b0, slot: '0};
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if (b[s] == '0) begin
        r.found = 1'b1;
        r.slot  = SLOT_W'(s);
      end
    end
    return r;
  endfunction

  function automatic bucket_t set_slot(bucket_t b, logic [SLOT_W-1:0] s, fp_t fp);
    bucket_t r;
    r    = b;
    r[s] = fp;
    return r;
  endfunction

endpackage

// File: rtl/ckf_fp_reduce.sv
// ----------------------------------------------------------------------------
// ckf_fp_reduce: digit-serial fingerprint reduction
// Reduces a 64-bit hash modulo 127 one 7-bit digit per cycle, using the fact
// that 128 is congruent to 1, with one add and conditional subtract.
// ----------------------------------------------------------------------------
module ckf_fp_reduce import ckf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [HASH_W-1:0] value,
  output logic              valid,
  output fp_t               rem
);

  logic [HASH_W-1:0]    shreg;
  logic [DIG_CNT_W-1:0] cnt;
  logic                 running;
  logic [FINGERPRINT_BITS:0] sum;
  fp_t                  acc_next;

  always_comb begin
    sum = {1'b0, rem} + {1'b0, shreg[FINGERPRINT_BITS-1:0]};
    if (sum >= (FINGERPRINT_BITS+1)'(FP_MOD)) begin
      acc_next = fp_t'(sum - (FINGERPRINT_BITS+1)'(FP_MOD));
    end else begin
      acc_next = fp_t'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      valid   <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (load) begin
        shreg   <= value;
        rem     <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem   <= acc_next;
        shreg <= shreg >> FINGERPRINT_BITS;
        cnt   <= cnt + DIG_CNT_W'(1);
        if (cnt == DIG_CNT_W'(DIGITS - 1)) begin
          running <= 1'b0;
          valid   <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/ckf_bucket_ram.sv
// ----------------------------------------------------------------------------
// ckf_bucket_ram: bucket store
// Single-port memory of buckets with a registered read.
// ----------------------------------------------------------------------------
module ckf_bucket_ram import ckf_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output bucket_t  rdata
);

  bucket_t mem [MAX_BUCKETS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

// File: rtl/cuckoo_filter_insert_lookup.sv
// ----------------------------------------------------------------------------
// cuckoo_filter_insert_lookup: cuckoo filter with insert and lookup
// Sequencer around a digit-serial fingerprint reducer and a single-port
// bucket store, with kick-chain relocation on a full insert.
// ----------------------------------------------------------------------------
//  channel   signals                                  transaction
//  request   start, busy, req_type, key_hash,         start high, busy low
//            fingerprint_hash
//  result    done, hit, status                        done high for one cycle
//  config    cfg_we, cfg_wdata                        cfg_we high
//
// While busy is high after the accepting edge, the fingerprint reducer works
// through ten 7-bit digits and hands over the remainder, then ST_RD1, ST_RD2
// and ST_CHECK read and check both buckets. done is registered and rises as
// busy falls, and a new request can be accepted in that cycle. Each kick
// passes through ST_KREAD and ST_KCHECK on the single memory port, up to 500
// kicks. After reset the store is cleared one bucket a cycle, all 1024
// buckets, while busy is high. The result cannot be stalled.
// ----------------------------------------------------------------------------
module cuckoo_filter_insert_lookup import ckf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [HASH_W-1:0] key_hash,
  input  logic [HASH_W-1:0] fingerprint_hash,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              done,
  output logic              hit,
  output logic [1:0]        status
);

  state_t            state, state_next;
  logic [CFG_W-1:0]  bucket_count_log2;
  idx_t              mask;
  logic              req;
  idx_t              i1, i2, i2_next;
  fp_t               fp, fp_next;
  bucket_t           b1, b1_next;
  idx_t              cur, cur_next;
  fp_t               carried, carried_next;
  logic [KICK_W-1:0] kick_cnt, kick_cnt_next;
  idx_t              clr_addr;
  logic              done_next, hit_next;
  status_t           status_reg, status_next;
  ram_req_t          ram_req;
  bucket_t           rdata;
  logic              red_valid;
  fp_t               red_rem;
  logic              accept;
  logic              h;
  empty_t            e1, e2;

  assign mask   = index_mask(bucket_count_log2);
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign status = status_reg;

  ckf_fp_reduce u_reduce (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .value (fingerprint_hash),
    .valid (red_valid),
    .rem   (red_rem)
  );

  ckf_bucket_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  always_comb begin
    state_next    = state;
    fp_next       = fp;
    i2_next       = i2;
    b1_next       = b1;
    cur_next      = cur;
    carried_next  = carried;
    kick_cnt_next = kick_cnt;
    done_next     = 1'b0;
    hit_next      = hit;
    status_next   = status_reg;
    ram_req       = '{we: 1'b0, addr: cur, wdata: rdata};
    h             = bucket_holds(b1, fp) || bucket_holds(rdata, fp);
    e1            = first_empty(b1);
    e2            = first_empty(rdata);
    unique case (state)
      ST_CLEAR: begin
        ram_req = '{we: 1'b1, addr: clr_addr, wdata: '0};
        if (clr_addr == {IDX_W{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_valid) begin
          fp_next    = red_rem + fp_t'(1);
          i2_next    = (i1 ^ idx_t'(red_rem + fp_t'(1))) & mask;
          state_next = ST_RD1;
        end
      end
      ST_RD1: begin
        ram_req.addr = i1;
        state_next   = ST_RD2;
      end
      ST_RD2: begin
        ram_req.addr = i2;
        b1_next      = rdata;
        state_next   = ST_CHECK;
      end
      ST_CHECK: begin
        if (!req) begin
          done_next   = 1'b1;
          hit_next    = h;
          status_next = STATUS_LOOKUP;
          state_next  = ST_IDLE;
        end else if (h) begin
          done_next   = 1'b1;
          hit_next    = 1'b1;
          status_next = STATUS_PRESENT;
          state_next  = ST_IDLE;
        end else if (e1.found) begin
          ram_req     = '{we: 1'b1, addr: i1, wdata: set_slot(b1, e1.slot, fp)};
          done_next   = 1'b1;
          hit_next    = 1'b0;
          status_next = STATUS_INSERTED;
          state_next  = ST_IDLE;
        end else if (e2.found) begin
          ram_req     = '{we: 1'b1, addr: i2, wdata: set_slot(rdata, e2.slot, fp)};
          done_next   = 1'b1;
          hit_next    = 1'b0;
          status_next = STATUS_INSERTED;
          state_next  = ST_IDLE;
        end else begin
          ram_req       = '{we: 1'b1, addr: i1, wdata: set_slot(b1, '0, fp)};
          carried_next  = b1[0];
          cur_next      = (i1 ^ idx_t'(b1[0])) & mask;
          kick_cnt_next = KICK_W'(1);
          state_next    = ST_KREAD;
        end
      end
      ST_KREAD: begin
        ram_req.addr = cur;
        state_next   = ST_KCHECK;
      end
      ST_KCHECK: begin
        if (e2.found) begin
          ram_req     = '{we: 1'b1, addr: cur, wdata: set_slot(rdata, e2.slot, carried)};
          done_next   = 1'b1;
          hit_next    = 1'b0;
          status_next = STATUS_INSERTED;
          state_next  = ST_IDLE;
        end else if (kick_cnt == KICK_W'(MAX_KICKS)) begin
          done_next   = 1'b1;
          hit_next    = 1'b0;
          status_next = STATUS_FULL;
          state_next  = ST_IDLE;
        end else begin
          ram_req       = '{we: 1'b1, addr: cur, wdata: set_slot(rdata, '0, carried)};
          carried_next  = rdata[0];
          cur_next      = (cur ^ idx_t'(rdata[0])) & mask;
          kick_cnt_next = kick_cnt + KICK_W'(1);
          state_next    = ST_KREAD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      clr_addr          <= '0;
      done              <= 1'b0;
      bucket_count_log2 <= CFG_W'(CFG_RESET);
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + idx_t'(1);
      end
      if (cfg_we) begin
        bucket_count_log2 <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= req_type;
      i1  <= key_hash[IDX_W-1:0] & mask;
    end
    fp         <= fp_next;
    i2         <= i2_next;
    b1         <= b1_next;
    cur        <= cur_next;
    carried    <= carried_next;
    kick_cnt   <= kick_cnt_next;
    hit        <= hit_next;
    status_reg <= status_next;
  end

endmodule
